// File: rtl/gtf_pkg.sv
package gtf_pkg;

    localparam int ID_COUNT = 1024;
    localparam int TEAMS    = 64;
    localparam int NODES    = 1024;

    localparam int ID_W     = 10;
    localparam int TEAM_W   = 7;
    localparam int TIDX_W   = $clog2(TEAMS);
    localparam int NODE_W   = $clog2(NODES);
    localparam int NCNT_W   = $clog2(NODES + 1);
    localparam int OCNT_W   = $clog2(TEAMS + 1);
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNASSIGNED = 2'd3;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [TEAM_W-1:0] team_t;
    typedef logic [TIDX_W-1:0] tidx_t;
    typedef logic [NODE_W-1:0] node_t;

endpackage

// File: rtl/grouped_team_fifo_core.sv
// Grouped FIFO of item ids: ids are assigned to teams, enqueue puts an id behind
// the last waiting member of its team, dequeue returns the oldest item of the
// front team. A request is taken when start is high and busy is low; its result
// appears on out_id, status and all_empty for exactly one cycle with done high,
// and the receiver cannot stall it. Assign and clear answer from one state each;
// an enqueue passes S_ENQ1, where a rejection answers, then S_ENQ2; a dequeue
// passes S_DEQ1, where an empty queue answers, then S_DEQ2 and S_DEQ3. The next
// request can be taken in the cycle the result shows. The steps come from the
// registered reads of the memories: dequeue walks the chain team order, team
// head/tail, node store one read per cycle. After reset busy stays high while
// the team membership memory is cleared one entry a cycle.
module grouped_team_fifo_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [gtf_pkg::OP_W-1:0]   operation,
    input  logic [gtf_pkg::ID_W-1:0]   item_id,
    input  logic [gtf_pkg::TEAM_W-1:0] team,
    output logic                       done,
    output logic [gtf_pkg::ID_W-1:0]   out_id,
    output logic [gtf_pkg::STAT_W-1:0] status,
    output logic                       all_empty
);
    import gtf_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ASSIGN = 4'd2;
    localparam logic [3:0] S_CLEAR  = 4'd3;
    localparam logic [3:0] S_ENQ1   = 4'd4;
    localparam logic [3:0] S_ENQ2   = 4'd5;
    localparam logic [3:0] S_DEQ1   = 4'd6;
    localparam logic [3:0] S_DEQ2   = 4'd7;
    localparam logic [3:0] S_DEQ3   = 4'd8;

    // memories
    team_t membership_mem [ID_COUNT];
    id_t   node_value_mem [NODES];
    node_t node_next_mem  [NODES];
    logic [2*NODE_W-1:0] team_mem [TEAMS];
    tidx_t order_mem      [TEAMS];

    // memory ports
    logic          mem_we;
    id_t           mem_waddr;
    team_t         mem_wdata;
    team_t         mem_rdata;
    logic          val_we;
    node_t         val_waddr;
    id_t           val_wdata;
    id_t           val_rdata;
    logic          nxt_we;
    node_t         nxt_waddr;
    node_t         nxt_wdata;
    node_t         nxt_rdata;
    node_t         node_raddr;
    logic          team_we;
    tidx_t         team_waddr;
    logic [2*NODE_W-1:0] team_wdata;
    logic [2*NODE_W-1:0] team_rdata;
    tidx_t         team_raddr;
    logic          ord_we;
    tidx_t         ord_waddr;
    tidx_t         ord_wdata;
    tidx_t         ord_rdata;

    // control state
    logic [3:0]        state_reg, state_next;
    id_t               init_cnt_reg, init_cnt_next;
    node_t             free_head_reg, free_head_next;
    logic [NCNT_W-1:0] fresh_count_reg, fresh_count_next;
    logic [NCNT_W-1:0] used_count_reg, used_count_next;
    logic [TEAMS-1:0]  team_waiting_reg, team_waiting_next;
    tidx_t             order_front_reg, order_front_next;
    logic [OCNT_W-1:0] order_count_reg, order_count_next;
    logic              done_reg;

    // payload
    id_t   id_reg, id_next;
    team_t team_reg, team_next;
    tidx_t tidx_reg, tidx_next;
    node_t nn_reg, nn_next;
    node_t head_reg, head_next;
    node_t tail_reg, tail_next;
    id_t   out_id_reg;
    logic [STAT_W-1:0] status_reg;
    logic  all_empty_reg;

    // response
    logic              resp_valid;
    id_t               resp_id;
    logic [STAT_W-1:0] resp_status;

    tidx_t             mem_team_m1;
    node_t             new_node;
    logic              use_free;
    tidx_t             order_sum;

    assign mem_team_m1 = tidx_t'(mem_rdata - team_t'(1));
    assign use_free    = (used_count_reg < fresh_count_reg);
    assign new_node    = use_free ? free_head_reg : fresh_count_reg[NODE_W-1:0];
    assign order_sum   = order_front_reg + order_count_reg[TIDX_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        init_cnt_next     = init_cnt_reg;
        free_head_next    = free_head_reg;
        fresh_count_next  = fresh_count_reg;
        used_count_next   = used_count_reg;
        team_waiting_next = team_waiting_reg;
        order_front_next  = order_front_reg;
        order_count_next  = order_count_reg;
        id_next           = id_reg;
        team_next         = team_reg;
        tidx_next         = tidx_reg;
        nn_next           = nn_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;

        resp_valid  = 1'b0;
        resp_id     = '0;
        resp_status = ST_OK;

        mem_we     = 1'b0;
        mem_waddr  = id_reg;
        mem_wdata  = '0;
        val_we     = 1'b0;
        val_waddr  = new_node;
        val_wdata  = id_reg;
        nxt_we     = 1'b0;
        nxt_waddr  = head_reg;
        nxt_wdata  = free_head_reg;
        node_raddr = free_head_reg;
        team_we    = 1'b0;
        team_waddr = tidx_reg;
        team_wdata = '0;
        team_raddr = tidx_reg;
        ord_we     = 1'b0;
        ord_waddr  = order_sum;
        ord_wdata  = tidx_reg;

        case (state_reg)
            S_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_cnt_reg;
                init_cnt_next = init_cnt_reg + id_t'(1);
                if (init_cnt_reg == id_t'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // membership, order and node reads start here for every request
                if (start)
                begin
                    id_next   = item_id;
                    team_next = team;
                    case (operation)
                        OP_ASSIGN:  state_next = S_ASSIGN;
                        OP_ENQUEUE: state_next = S_ENQ1;
                        OP_DEQUEUE: state_next = S_DEQ1;
                        default:    state_next = S_CLEAR;
                    endcase
                end
            end
            S_ASSIGN:
            begin
                mem_we     = 1'b1;
                resp_valid = 1'b1;
                if (team_reg == '0 || team_reg > team_t'(TEAMS))
                begin
                    mem_wdata   = '0;
                    resp_status = ST_UNASSIGNED;
                end
                else
                begin
                    mem_wdata = team_reg;
                end
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                free_head_next    = '0;
                fresh_count_next  = '0;
                used_count_next   = '0;
                order_front_next  = '0;
                order_count_next  = '0;
                team_waiting_next = '0;
                resp_valid        = 1'b1;
                state_next        = S_IDLE;
            end
            S_ENQ1:
            begin
                team_raddr = mem_team_m1;
                tidx_next  = mem_team_m1;
                nn_next    = nxt_rdata;
                if (mem_rdata == '0 || mem_rdata > team_t'(TEAMS))
                begin
                    resp_valid  = 1'b1;
                    resp_status = ST_UNASSIGNED;
                    state_next  = S_IDLE;
                end
                else if (used_count_reg >= NCNT_W'(NODES))
                begin
                    resp_valid  = 1'b1;
                    resp_status = ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_ENQ2;
                end
            end
            S_ENQ2:
            begin
                val_we = 1'b1;
                if (use_free)
                begin
                    free_head_next = nn_reg;
                end
                else
                begin
                    fresh_count_next = fresh_count_reg + NCNT_W'(1);
                end
                used_count_next = used_count_reg + NCNT_W'(1);
                team_we         = 1'b1;
                if (team_waiting_reg[tidx_reg])
                begin
                    // link behind the current tail of the team
                    nxt_we     = 1'b1;
                    nxt_waddr  = team_rdata[NODE_W-1:0];
                    nxt_wdata  = new_node;
                    team_wdata = {team_rdata[2*NODE_W-1:NODE_W], new_node};
                end
                else
                begin
                    team_waiting_next[tidx_reg] = 1'b1;
                    team_wdata = {new_node, new_node};
                    if (order_count_reg < OCNT_W'(TEAMS))
                    begin
                        ord_we           = 1'b1;
                        order_count_next = order_count_reg + OCNT_W'(1);
                    end
                end
                resp_valid = 1'b1;
                state_next = S_IDLE;
            end
            S_DEQ1:
            begin
                team_raddr = ord_rdata;
                tidx_next  = ord_rdata;
                if (order_count_reg == '0 || used_count_reg == '0)
                begin
                    resp_valid  = 1'b1;
                    resp_status = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_DEQ2;
                end
            end
            S_DEQ2:
            begin
                head_next  = team_rdata[2*NODE_W-1:NODE_W];
                tail_next  = team_rdata[NODE_W-1:0];
                node_raddr = team_rdata[2*NODE_W-1:NODE_W];
                state_next = S_DEQ3;
            end
            S_DEQ3:
            begin
                resp_id = val_rdata;
                if (head_reg == tail_reg)
                begin
                    team_waiting_next[tidx_reg] = 1'b0;
                    order_front_next = order_front_reg + tidx_t'(1);
                    order_count_next = order_count_reg - OCNT_W'(1);
                end
                else
                begin
                    team_we    = 1'b1;
                    team_wdata = {nxt_rdata, tail_reg};
                end
                // freed node goes onto the recycle list
                nxt_we          = 1'b1;
                free_head_next  = head_reg;
                used_count_next = used_count_reg - NCNT_W'(1);
                resp_valid      = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            init_cnt_reg     <= '0;
            free_head_reg    <= '0;
            fresh_count_reg  <= '0;
            used_count_reg   <= '0;
            team_waiting_reg <= '0;
            order_front_reg  <= '0;
            order_count_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            init_cnt_reg     <= init_cnt_next;
            free_head_reg    <= free_head_next;
            fresh_count_reg  <= fresh_count_next;
            used_count_reg   <= used_count_next;
            team_waiting_reg <= team_waiting_next;
            order_front_reg  <= order_front_next;
            order_count_reg  <= order_count_next;
            done_reg         <= resp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        team_reg <= team_next;
        tidx_reg <= tidx_next;
        nn_reg   <= nn_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (resp_valid)
        begin
            out_id_reg    <= resp_id;
            status_reg    <= resp_status;
            all_empty_reg <= (used_count_next == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            membership_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= membership_mem[item_id];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            node_value_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= node_value_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            node_next_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rdata <= node_next_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (team_we)
        begin
            team_mem[team_waddr] <= team_wdata;
        end
        team_rdata <= team_mem[team_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata <= order_mem[order_front_reg];
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign out_id    = out_id_reg;
    assign status    = status_reg;
    assign all_empty = all_empty_reg;

endmodule

// File: rtl/gtf_checker.sv
module gtf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [gtf_pkg::OP_W-1:0]   operation,
    input logic [gtf_pkg::TEAM_W-1:0] team,
    input logic                       done,
    input logic [gtf_pkg::ID_W-1:0]   out_id,
    input logic [gtf_pkg::STAT_W-1:0] status,
    input logic                       all_empty
);
    import gtf_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // a result shows only once the block is ready for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // every request keeps the block busy, with no result, in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done))
        else $error("request not held busy");

    // a failed request returns no id: out_id is zero
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (out_id == '0))
        else $error("failed request returned an id");

    // clear answers with status OK and everything empty
    a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_CLEAR) |-> ##2 (done && status == ST_OK && all_empty))
        else $error("clear response wrong");

    // assign with team zero is refused as unassigned
    a_assign_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_ASSIGN && team == '0)
            |-> ##2 (done && status == ST_UNASSIGNED))
        else $error("bad assign not refused");

endmodule

bind grouped_team_fifo_core gtf_checker u_gtf_checker (.*);
